// ===== rtl/lsxc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the login stream XOR cipher.
// Depends on nothing; imported by login_stream_xor_cipher and its testbench.
package lsxc_pkg;

   typedef logic [31:0] word_type;
   typedef logic [4:0]  shamt_type;
   typedef logic [2:0]  step_type;

   // Field widths of the stream payloads and of the configuration index.
   localparam int unsigned SEED_W     = 32;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned CSR_IDX_W  = 3;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ONE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_TWO     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_THREE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_MASK   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CIPHER_MODE = 3'd4;

   // Key update rules.
   localparam logic [1:0] MODE_NEW = 2'd0;
   localparam logic [1:0] MODE_OLD = 2'd1;
   localparam logic [1:0] MODE_MUL = 2'd2;

   // Item kinds carried in tuser.
   localparam logic ACT_LOAD    = 1'b0;
   localparam logic ACT_ENCRYPT = 1'b1;

   // Seed mixing constants.
   localparam word_type MIX_LOW_XOR  = 32'hffffaaaa;
   localparam word_type MIX_HIGH_XOR = 32'h43210000;
   localparam word_type MIX_HIGH_INV = 32'habcdffff;
   localparam word_type LOW_HALF     = 32'h0000ffff;
   localparam word_type HIGH_HALF    = 32'hffff0000;

   // Multiply-based rule constants.
   localparam word_type MUL_A = 32'h35ce9581;
   localparam word_type ADD_A = 32'h07afcc37;
   localparam word_type MUL_B = 32'h4c3a1353;
   localparam word_type ADD_B = 32'h16ef783f;

   // Sequencer steps of the multiply-based rule, one product per step.
   localparam step_type STEP_SQ_HI  = 3'd0;
   localparam step_type STEP_SQ_LO  = 3'd1;
   localparam step_type STEP_HI_K1  = 3'd2;
   localparam step_type STEP_SQ_MA  = 3'd3;
   localparam step_type STEP_SQ_NH  = 3'd4;
   localparam step_type STEP_SQ_MB  = 3'd5;
   localparam step_type STEP_LO_K2  = 3'd6;

endpackage

// ===== rtl/login_stream_xor_cipher.sv =====
`timescale 1ns / 1ps
// Login stream XOR cipher: seed loading, byte encryption and key update.
// Depends on lsxc_pkg for constants and types.
// A result is registered on rsp in the cycle after its item is accepted.
// Load items, and encrypt items under rules 0, 1 and 3, never make the block busy.
// Under the multiply-based rule an accepted encrypt item keeps the block busy for seven
// steps of the single shared 32x32 multiplier, whose products depend on one another.
// Synchronous active-high reset clears configuration, key, sequencer and rsp_tvalid.
module login_stream_xor_cipher
   import lsxc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // session_seed[31:0], data_in[39:32]
   input  logic                  req_tuser,  // action
   input  logic                  req_tlast,  // block_end
   // Result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [BYTE_W-1:0]     rsp_tdata,  // data_out[7:0]
   output logic                  rsp_tlast,  // block_end_out
   // Configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [SEED_W-1:0]     csr_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_BUSY = 1'b1;

   // Configuration registers.
   word_type   key_one_ff, key_two_ff, key_three_ff, seed_mask_ff;
   logic [1:0] mode_ff;

   // Key state and sequencer.
   word_type   key_low_ff, key_low_in;
   word_type   key_high_ff, key_high_in;
   logic       state_ff, state_in;
   step_type   step_ff, step_in;
   word_type   acc_ff, acc_in;
   word_type   sq_ff, sq_in;
   shamt_type  sh_hi_ff, sh_hi_in;
   shamt_type  sh_lo_ff, sh_lo_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic        req_accept;
   logic        is_encrypt;
   word_type    seed;
   logic [BYTE_W-1:0] data_in;
   word_type    mul_a, mul_b, mul_prod;
   word_type    shift_src, shift_res;
   shamt_type   shift_amt;
   word_type    add_base, add_term, add_sum;
   word_type    lo_rot, hi_rot;

   assign seed       = req_tdata[SEED_W-1:0];
   assign data_in    = req_tdata[REQ_DATA_W-1:SEED_W];
   assign is_encrypt = (req_tuser == ACT_ENCRYPT);

   // Accept only when idle and the output register is free or draining.
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Configuration register writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_one_ff   <= '0;
         key_two_ff   <= '0;
         key_three_ff <= '0;
         seed_mask_ff <= '0;
         mode_ff      <= MODE_NEW;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KEY_ONE:     key_one_ff   <= csr_data;
            CSR_KEY_TWO:     key_two_ff   <= csr_data;
            CSR_KEY_THREE:   key_three_ff <= csr_data;
            CSR_SEED_MASK:   seed_mask_ff <= csr_data;
            CSR_CIPHER_MODE: mode_ff      <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // Shared multiplier: operands chosen by the sequencer step.
   always_comb begin
      case (step_ff)
         STEP_SQ_HI: begin mul_a = key_high_ff; mul_b = key_high_ff; end
         STEP_SQ_LO: begin mul_a = key_low_ff;  mul_b = key_low_ff;  end
         STEP_HI_K1: begin mul_a = key_high_ff; mul_b = key_one_ff;  end
         STEP_SQ_MA: begin mul_a = sq_ff;       mul_b = MUL_A;       end
         STEP_SQ_NH: begin mul_a = key_high_ff; mul_b = key_high_ff; end
         STEP_SQ_MB: begin mul_a = sq_ff;       mul_b = MUL_B;       end
         STEP_LO_K2: begin mul_a = key_low_ff;  mul_b = key_two_ff;  end
         default:    begin mul_a = '0;          mul_b = '0;          end
      endcase
   end

   assign mul_prod = mul_a * mul_b;

   // Shared barrel shifter for the two key-constant shifts.
   assign shift_src = (step_ff == STEP_SQ_LO) ? key_one_ff : key_two_ff;
   assign shift_amt = (step_ff == STEP_SQ_LO) ? sh_hi_ff : sh_lo_ff;
   assign shift_res = shift_src >> shift_amt;

   // Adder: acc+product; acc+shift at STEP_SQ_LO; ADD_B+shift at STEP_SQ_NH.
   always_comb begin
      add_base = acc_ff;
      add_term = mul_prod;
      case (step_ff)
         STEP_SQ_LO: add_term = shift_res;
         STEP_SQ_NH: begin
            add_base = ADD_B;
            add_term = shift_res;
         end
         default: ;
      endcase
   end

   assign add_sum = add_base + add_term;

   // Rotated halves used by the shift/XOR rules.
   assign lo_rot = {key_high_ff[0], key_low_ff[31:1]};
   assign hi_rot = {key_low_ff[0], key_high_ff[31:1]};

   // Next-state logic for the key, sequencer and output register.
   always_comb begin
      key_low_in   = key_low_ff;
      key_high_in  = key_high_ff;
      state_in     = state_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      sh_hi_in     = sh_hi_ff;
      sh_lo_in     = sh_lo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (state_ff == ST_IDLE) begin
         if (req_accept && !is_encrypt) begin
            // Load the key from the session seed.
            key_low_in  = (((~seed) ^ seed_mask_ff) << 16) | ((seed ^ MIX_LOW_XOR) & LOW_HALF);
            key_high_in = ((seed ^ MIX_HIGH_XOR) >> 16) | (((~seed) ^ MIX_HIGH_INV) & HIGH_HALF);
         end else if (req_accept) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = data_in ^ key_low_ff[BYTE_W-1:0];
            rsp_last_in  = req_tlast;
            case (mode_ff)
               MODE_OLD: begin
                  key_low_in  = lo_rot ^ key_two_ff;
                  key_high_in = hi_rot ^ key_one_ff;
               end
               MODE_MUL: begin
                  state_in = ST_BUSY;
                  step_in  = STEP_SQ_HI;
               end
               default: begin
                  key_high_in = ({key_low_ff[0], hi_rot[31:1] ^ key_one_ff[31:1]})
                                ^ key_two_ff;
                  key_low_in  = lo_rot ^ key_three_ff;
               end
            endcase
         end
      end else begin
         // Multiply-based rule, one product per step.
         step_in = step_ff + 3'd1;
         case (step_ff)
            STEP_SQ_HI: begin
               sh_hi_in = mul_prod[4:0] + {mul_prod[2:0], 2'b00};
               acc_in   = ADD_A;
            end
            STEP_SQ_LO: begin
               sh_lo_in = mul_prod[4:0] + {mul_prod[3:0], 1'b0};
               sq_in    = mul_prod;
               acc_in   = add_sum;
            end
            STEP_SQ_MA: begin
               acc_in      = add_sum;
               key_high_in = add_sum;
            end
            STEP_SQ_NH: begin
               sq_in  = mul_prod;
               acc_in = add_sum;
            end
            STEP_LO_K2: begin
               acc_in     = add_sum;
               key_low_in = add_sum;
               state_in   = ST_IDLE;
            end
            default: acc_in = add_sum;
         endcase
      end
   end

   // Control and key state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_SQ_HI;
         key_low_ff   <= '0;
         key_high_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         key_low_ff   <= key_low_in;
         key_high_ff  <= key_high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      sq_ff       <= sq_in;
      sh_hi_ff    <= sh_hi_in;
      sh_lo_ff    <= sh_lo_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

`ifndef SYNTHESIS
   // No item is taken while the sequencer runs.
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BUSY) |-> !req_tready)
      else $error("item accepted during key update");

   // The sequencer never runs past its last step.
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BUSY) |-> (step_ff <= STEP_LO_K2))
      else $error("sequencer step out of range");

   // The last step always returns the block to idle.
   a_last_step_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BUSY && step_ff == STEP_LO_K2) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not finish");

   // An accepted encrypt item always presents a result next cycle.
   a_encrypt_result: assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_encrypt) |=> rsp_tvalid)
      else $error("encrypt item gave no result");

   // A load item never creates a result.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !is_encrypt && !rsp_valid_ff) |=> !rsp_tvalid)
      else $error("load item gave a result");
`endif

endmodule

// ===== bench/tb_login_stream_xor_cipher.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for login_stream_xor_cipher: seed loads, byte encryption and all key rules.
// Depends on lsxc_pkg and the login_stream_xor_cipher RTL; predicts every ciphertext item in-bench.
module tb_login_stream_xor_cipher;
   import lsxc_pkg::*;

   // Spare rule value, which the block treats as the new rule.
   localparam logic [1:0] MODE_SPARE = 2'd3;

   // Receiver behaviour on the result channel.
   localparam int READY_ALWAYS  = 0;
   localparam int READY_RANDOM  = 1;
   localparam int READY_PATTERN = 2;

   localparam int SETTLE_CYCLES = 12;
   localparam int MAX_PRINTED   = 60;

   typedef struct packed {
      word_type lo;
      word_type hi;
   } key_pair_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } cipher_byte_type;

   // Clock and reset.
   logic clock = 1'b0;
   logic reset = 1'b1;

   // Block inputs, all known from time zero.
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // session_seed[31:0], data_in[39:32]
   logic                  req_tuser  = 1'b0;  // action
   logic                  req_tlast  = 1'b0;  // block_end
   logic                  rsp_tready = 1'b1;
   logic                  csr_valid  = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [SEED_W-1:0]     csr_data   = '0;

   // Block outputs.
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [BYTE_W-1:0]     rsp_tdata;  // data_out[7:0]
   logic                  rsp_tlast;  // block_end_out
   logic                  csr_ready;

   // Shadow of the configuration and of the key state.
   word_type     shadow_key_one   = '0;
   word_type     shadow_key_two   = '0;
   word_type     shadow_key_three = '0;
   word_type     shadow_seed_mask = '0;
   logic [1:0]   shadow_rule      = MODE_NEW;
   key_pair_type shadow_key       = '0;

   // Ciphertext items still owed by the block, oldest first.
   cipher_byte_type pending_cipher[$];

   int err_count   = 0;
   int burst_left  = 0;
   bit send_gaps   = 1'b0;
   int ready_mode  = READY_ALWAYS;
   logic [15:0] stall_pattern = 16'hffff;
   logic [3:0]  pattern_pos   = '0;

   login_stream_xor_cipher u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Key words set by a seed load.
   function automatic key_pair_type seeded_key(input word_type seed);
      key_pair_type k;
      k.lo = ((~seed ^ shadow_seed_mask) << 16) | ((seed ^ MIX_LOW_XOR) & LOW_HALF);
      k.hi = ((seed ^ MIX_HIGH_XOR) >> 16) | ((~seed ^ MIX_HIGH_INV) & HIGH_HALF);
      return k;
   endfunction

   // Key words after one encrypted byte, under the current rule.
   function automatic key_pair_type advanced_key(input key_pair_type k);
      key_pair_type n;
      word_type  sq_hi, sq_lo, nh, nl;
      shamt_type sh_hi, sh_lo;
      case (shadow_rule)
         MODE_OLD: begin
            n.lo = ((k.lo >> 1) | (k.hi << 31)) ^ shadow_key_two;
            n.hi = ((k.hi >> 1) | (k.lo << 31)) ^ shadow_key_one;
         end
         MODE_MUL: begin
            // All products wrap at 32 bits; the shift counts keep five bits only.
            sq_hi = 32'd5 * k.hi * k.hi;
            sq_lo = 32'd3 * k.lo * k.lo;
            sh_hi = sq_hi[4:0];
            sh_lo = sq_lo[4:0];
            nh = (shadow_key_one >> sh_hi) + k.hi * shadow_key_one + k.lo * k.lo * MUL_A + ADD_A;
            nl = (shadow_key_two >> sh_lo) + k.lo * shadow_key_two + nh * nh * MUL_B + ADD_B;
            n.hi = nh;
            n.lo = nl;
         end
         default: begin
            // The new rule, also taken for the spare rule value.
            n.hi = (((((k.hi >> 1) | (k.lo << 31)) ^ shadow_key_one) >> 1) | (k.lo << 31))
                   ^ shadow_key_two;
            n.lo = ((k.lo >> 1) | (k.hi << 31)) ^ shadow_key_three;
         end
      endcase
      return n;
   endfunction

   // Random word that lands on the extremes now and then.
   function automatic word_type pick_word();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      if (err_count < MAX_PRINTED)
         $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
      err_count++;
   endtask

   // Send one input item, then bring the shadow key up to date once it is accepted.
   task automatic send_item(input logic act, input word_type seed, input logic [BYTE_W-1:0] data,
                            input logic last);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = send_gaps ? $urandom_range(1, 6) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {data, seed};
      req_tuser  <= act;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if (act == ACT_LOAD) begin
         shadow_key = seeded_key(seed);
      end else begin
         pending_cipher.push_back('{data: data ^ shadow_key.lo[BYTE_W-1:0], last: last});
         shadow_key = advanced_key(shadow_key);
      end
   endtask

   // Write one register through the configuration channel.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input word_type value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_KEY_ONE:     shadow_key_one   = value;
         CSR_KEY_TWO:     shadow_key_two   = value;
         CSR_KEY_THREE:   shadow_key_three = value;
         CSR_SEED_MASK:   shadow_seed_mask = value;
         CSR_CIPHER_MODE: shadow_rule      = value[1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stop sending, let every owed item arrive, then allow the multiply sequence to settle.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_cipher.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Encrypt straight after reset: the key is still zero and the rule is the new one.
   task automatic test_unloaded_key();
      send_item(ACT_ENCRYPT, $urandom, 8'h00, 1'b0);
      send_item(ACT_ENCRYPT, $urandom, 8'hff, 1'b1);
      send_item(ACT_ENCRYPT, $urandom, 8'($urandom), 1'b1);
      wait_idle();
   endtask

   // Writes beyond the last register must leave the configuration alone.
   task automatic test_ignored_index();
      for (int i = CSR_CIPHER_MODE + 1; i < (1 << CSR_IDX_W); i++)
         write_csr(i[CSR_IDX_W-1:0], '1);
      send_item(ACT_LOAD, $urandom, 8'($urandom), 1'b1);
      send_item(ACT_ENCRYPT, $urandom, 8'($urandom), 1'b0);
      send_item(ACT_ENCRYPT, $urandom, 8'($urandom), 1'b1);
      wait_idle();
   endtask

   // Every rule, including the spare value, with extreme keys, masks and seeds.
   task automatic test_rule_extremes();
      logic [1:0] rules[4];
      word_type   ext;
      rules = '{MODE_NEW, MODE_OLD, MODE_MUL, MODE_SPARE};
      foreach (rules[i]) begin
         ext = rules[i][0] ? '1 : '0;
         write_csr(CSR_KEY_ONE, ext);
         write_csr(CSR_KEY_TWO, ~ext);
         write_csr(CSR_KEY_THREE, '1);
         write_csr(CSR_SEED_MASK, rules[i][1] ? '1 : '0);
         // Upper bits set to show that only the low two bits select the rule.
         write_csr(CSR_CIPHER_MODE, {30'h3fffffff, rules[i]});
         send_item(ACT_LOAD, ext, 8'($urandom), 1'($urandom_range(0, 1)));
         send_item(ACT_ENCRYPT, ~ext, 8'h00, 1'b0);
         send_item(ACT_ENCRYPT, $urandom, 8'hff, 1'b0);
         send_item(ACT_ENCRYPT, $urandom, 8'($urandom), 1'b1);
         wait_idle();
      end
   endtask

   // Phases of random traffic, each under a fresh configuration and idling regime.
   task automatic test_random_traffic();
      int         sent;
      int         buf_len;
      logic [1:0] rule;
      for (int phase = 0; phase < 10; phase++) begin
         rule = (phase < 8) ? phase[1:0] : 2'($urandom_range(0, 3));
         write_csr(CSR_KEY_ONE, pick_word());
         write_csr(CSR_KEY_TWO, pick_word());
         write_csr(CSR_KEY_THREE, pick_word());
         write_csr(CSR_SEED_MASK, pick_word());
         write_csr(CSR_CIPHER_MODE, ($urandom & 32'hfffffffc) | rule);
         if ($urandom_range(0, 3) == 0)
            write_csr(CSR_IDX_W'($urandom_range(CSR_CIPHER_MODE + 1, (1 << CSR_IDX_W) - 1)),
                      $urandom);
         // The first phase runs flat out on both sides.
         send_gaps     = (phase != 0) && ($urandom_range(0, 3) != 0);
         ready_mode    = (phase == 0) ? READY_ALWAYS : $urandom_range(READY_RANDOM, READY_PATTERN);
         stall_pattern = 16'($urandom) | 16'h0101;
         sent = 0;
         while (sent < 80) begin
            if ($urandom_range(0, 9) < 8) begin
               // A well-formed buffer: a seed load, then bytes with the last one marked.
               buf_len = $urandom_range(1, 10);
               send_item(ACT_LOAD, $urandom, 8'($urandom), 1'($urandom_range(0, 1)));
               for (int b = 0; b < buf_len; b++)
                  send_item(ACT_ENCRYPT, $urandom, 8'($urandom), b == buf_len - 1);
               sent += buf_len + 1;
            end else begin
               // Noise: any kind of item with any marking.
               send_item(1'($urandom_range(0, 1)), $urandom, 8'($urandom),
                         1'($urandom_range(0, 1)));
               sent++;
            end
         end
         wait_idle();
      end
   endtask

   // Result receiver: stalls as the current regime says.
   always @(negedge clock) begin
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_RANDOM: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: begin
            rsp_tready  <= stall_pattern[pattern_pos];
            pattern_pos <= pattern_pos + 1'b1;
         end
      endcase
   end

   // Compare each accepted result with the oldest owed item.
   always @(posedge clock) begin
      cipher_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_cipher.size() == 0) begin
            report_mismatch("unexpected result item", int'(rsp_tdata), 0);
         end else begin
            want = pending_cipher.pop_front();
            if (rsp_tdata !== want.data)
               report_mismatch("data_out", int'(rsp_tdata), int'(want.data));
            if (rsp_tlast !== want.last)
               report_mismatch("block_end_out", int'(rsp_tlast), int'(want.last));
         end
      end
   end

   // Stimulus sequence.
   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_unloaded_key();
      test_ignored_index();
      test_rule_extremes();
      test_random_traffic();
      wait_idle();
      if (err_count == 0)
         $display("tb_login_stream_xor_cipher OK");
      else
         $display("tb_login_stream_xor_cipher NOT OK");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #2000000;
      $display("tb_login_stream_xor_cipher NOT OK");
      $finish;
   end

endmodule
